[src/smu_pkg.sv]
// Shared types, opcodes and term tables for the small matrix unit.
package smu_pkg;

	localparam int ELEMENT_WIDTH_DEF = 16;
	localparam int RESULT_WIDTH = 51;
	localparam int DEPTH = 9;

	localparam logic [3:0] OP_LOAD_A = 4'd0;
	localparam logic [3:0] OP_LOAD_B = 4'd1;
	localparam logic [3:0] OP_DET2 = 4'd2;
	localparam logic [3:0] OP_DET3 = 4'd3;
	localparam logic [3:0] OP_TR2 = 4'd4;
	localparam logic [3:0] OP_TR3 = 4'd5;
	localparam logic [3:0] OP_COF2 = 4'd6;
	localparam logic [3:0] OP_COF3 = 4'd7;
	localparam logic [3:0] OP_INV2 = 4'd8;
	localparam logic [3:0] OP_INV3 = 4'd9;
	localparam logic [3:0] OP_MUL2 = 4'd10;
	localparam logic [3:0] OP_MUL3 = 4'd11;
	localparam logic [3:0] OP_ADD2 = 4'd12;
	localparam logic [3:0] OP_ADD3 = 4'd13;
	localparam logic [3:0] LAST_INDEX = 4'd8;

	typedef struct packed {
		logic [3:0] opcode;
		logic [3:0] element_index;
		logic signed [15:0] element_value;
	} smu_in_t;

	typedef struct packed {
		logic signed [RESULT_WIDTH-1:0] result_value;
		logic [3:0] result_index;
		logic is_determinant;
		logic status;
		logic last;
	} smu_out_t;

	typedef struct packed {
		logic we_a;
		logic we_b;
		logic [3:0] addr;
	} smu_wr_t;

	typedef struct packed {
		logic [1:0] fac_cnt;
		logic neg;
		logic [2:0] from_b;
		logic [2:0][3:0] idx;
	} smu_term_t;

	localparam logic [3:0] TR3 [9] = '{4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8};
	localparam logic [1:0] ROW3 [9] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
	localparam logic [1:0] COL3 [9] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};

	localparam logic [3:0] DET3_IDX [6][3] = '{
		'{4'd0, 4'd4, 4'd8}, '{4'd1, 4'd5, 4'd6}, '{4'd2, 4'd3, 4'd7},
		'{4'd6, 4'd4, 4'd2}, '{4'd7, 4'd5, 4'd0}, '{4'd8, 4'd3, 4'd1}};

	// minor operands a, b, c, d of each cofactor: a*d - c*b
	localparam logic [3:0] COF3_IDX [9][4] = '{
		'{4'd4, 4'd5, 4'd7, 4'd8}, '{4'd3, 4'd5, 4'd6, 4'd8}, '{4'd3, 4'd4, 4'd6, 4'd7},
		'{4'd1, 4'd2, 4'd7, 4'd8}, '{4'd0, 4'd2, 4'd6, 4'd8}, '{4'd0, 4'd1, 4'd6, 4'd7},
		'{4'd1, 4'd2, 4'd4, 4'd5}, '{4'd0, 4'd2, 4'd3, 4'd5}, '{4'd0, 4'd1, 4'd3, 4'd4}};

	function automatic smu_term_t term_desc(input logic [3:0] op, input logic [3:0] e,
			input logic [2:0] t);
		smu_term_t d;
		logic [3:0] k;
		logic [1:0] r;
		logic [1:0] c;
		logic [1:0] m;
		d = '0;
		d.fac_cnt = 2'd1;
		k = 4'd0;
		r = 2'd0;
		c = 2'd0;
		m = 2'd0;
		case (op)
			OP_DET2: begin
				d.fac_cnt = 2'd2;
				d.neg = t[0];
				d.idx[0] = t[0] ? 4'd2 : 4'd0;
				d.idx[1] = t[0] ? 4'd1 : 4'd3;
			end
			OP_DET3: begin
				d.fac_cnt = 2'd3;
				d.neg = (t >= 3'd3);
				d.idx[0] = DET3_IDX[t][0];
				d.idx[1] = DET3_IDX[t][1];
				d.idx[2] = DET3_IDX[t][2];
			end
			OP_TR2: d.idx[0] = {2'b00, e[0], e[1]};
			OP_TR3: d.idx[0] = TR3[e];
			OP_COF2: begin
				d.idx[0] = 4'd3 - e;
				d.neg = (e == 4'd1) || (e == 4'd2);
			end
			OP_INV2: begin
				d.idx[0] = (e == 4'd0) ? 4'd3 : ((e == 4'd3) ? 4'd0 : e);
				d.neg = (e == 4'd1) || (e == 4'd2);
			end
			OP_COF3, OP_INV3: begin
				k = (op == OP_COF3) ? e : TR3[e];
				d.fac_cnt = 2'd2;
				if (!t[0]) begin
					d.idx[0] = COF3_IDX[k][0];
					d.idx[1] = COF3_IDX[k][3];
					d.neg = k[0];
				end else begin
					d.idx[0] = COF3_IDX[k][2];
					d.idx[1] = COF3_IDX[k][1];
					d.neg = !k[0];
				end
			end
			OP_MUL2: begin
				d.fac_cnt = 2'd2;
				d.from_b = 3'b010;
				d.idx[0] = {2'b00, e[1], t[0]};
				d.idx[1] = {2'b00, t[0], e[0]};
			end
			OP_MUL3: begin
				r = ROW3[e];
				c = COL3[e];
				m = t[1:0];
				d.fac_cnt = 2'd2;
				d.from_b = 3'b010;
				d.idx[0] = 4'({r, 1'b0}) + 4'(r) + 4'(m);
				d.idx[1] = 4'({m, 1'b0}) + 4'(m) + 4'(c);
			end
			OP_ADD2, OP_ADD3: begin
				d.idx[0] = e;
				d.from_b = {2'b00, t[0]};
			end
			default: ;
		endcase
		return d;
	endfunction

	function automatic logic [2:0] term_count(input logic [3:0] op);
		logic [2:0] n;
		case (op)
			OP_DET2, OP_COF3, OP_INV3, OP_MUL2, OP_ADD2, OP_ADD3: n = 3'd2;
			OP_DET3: n = 3'd6;
			OP_MUL3: n = 3'd3;
			default: n = 3'd1;
		endcase
		return n;
	endfunction

	function automatic logic [3:0] elem_count(input logic [3:0] op);
		logic [3:0] n;
		case (op)
			OP_DET2, OP_DET3: n = 4'd1;
			default: n = op[0] ? 4'd9 : 4'd4;
		endcase
		return n;
	endfunction

endpackage

[src/small_matrix_unit.sv]
// Small matrix unit: 2x2/3x3 determinant, transpose, cofactor, inverse, product, sum.
// Loads are written in the idle state. An operation builds each product term one factor
// at a time (read, then low and high multiply halves) and accumulates it, on one shared
// 33 x ELEMENT_WIDTH multiplier fed from the single read port of each store, and then
// emits each result, waiting while the output is held off; no new item is taken until idle.
// Reset returns the sequencer to idle, empties the output register and makes both
// stores read as all zero.
module small_matrix_unit
	import smu_pkg::*;
#(
	parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_ready,
	input smu_in_t cmd,
	output logic res_valid,
	input logic res_ready,
	output smu_out_t res
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RD   = 6'b000010,
		S_MLO  = 6'b000100,
		S_MHI  = 6'b001000,
		S_ACC  = 6'b010000,
		S_EMIT = 6'b100000
	} state_t;

	state_t state_q;
	logic [3:0] op_q;
	logic [3:0] e_q;
	logic [2:0] t_q;
	logic [1:0] fi_q;
	logic det_phase_q;
	logic res_valid_q;
	logic sel_b_q;
	logic signed [ELEMENT_WIDTH-1:0] fac_q;
	logic [63:0] prod_q;
	logic [63:0] tmp_q;
	logic [63:0] acc_q;
	logic [63:0] det_q;
	smu_out_t res_q;
	smu_out_t out_q;

	smu_wr_t wr;
	logic signed [ELEMENT_WIDTH-1:0] wr_data;
	logic signed [ELEMENT_WIDTH-1:0] rd_a;
	logic signed [ELEMENT_WIDTH-1:0] rd_b;
	logic [3:0] eff_op;
	smu_term_t desc;
	logic [2:0] nterm;
	logic [3:0] nelem;
	logic is_inv;
	logic is_det_op;
	logic accept;
	logic out_free;
	logic inv_final;
	logic signed [ELEMENT_WIDTH-1:0] fac_rd;
	logic signed [ELEMENT_WIDTH-1:0] fac_src;
	logic signed [32:0] mul_a;
	logic signed [32+ELEMENT_WIDTH:0] mul_res;
	logic [63:0] acc_sum;

	assign cmd_ready = (state_q == S_IDLE);
	assign accept = cmd_valid && cmd_ready;
	assign out_free = !res_valid_q || res_ready;
	assign res_valid = res_valid_q;
	assign res = out_q;

	assign wr.we_a = accept && (cmd.opcode == OP_LOAD_A) && (cmd.element_index <= LAST_INDEX);
	assign wr.we_b = accept && (cmd.opcode == OP_LOAD_B) && (cmd.element_index <= LAST_INDEX);
	assign wr.addr = cmd.element_index;
	assign wr_data = ELEMENT_WIDTH'(cmd.element_value);

	assign eff_op = det_phase_q ? (op_q[0] ? OP_DET3 : OP_DET2) : op_q;
	assign desc = term_desc(eff_op, e_q, t_q);
	assign nterm = term_count(eff_op);
	assign nelem = elem_count(op_q);
	assign is_inv = (op_q == OP_INV2) || (op_q == OP_INV3);
	assign is_det_op = (op_q == OP_DET2) || (op_q == OP_DET3);
	assign inv_final = is_inv && !res_q.is_determinant && (e_q == nelem - 4'd1);

	assign fac_rd = sel_b_q ? rd_b : rd_a;
	assign fac_src = (state_q == S_MLO) ? fac_rd : fac_q;
	assign mul_a = (state_q == S_MHI) ? {prod_q[63], prod_q[63:32]} : {1'b0, prod_q[31:0]};
	assign mul_res = mul_a * fac_src;
	assign acc_sum = acc_q + prod_q;

	smu_store #(
		.ELEMENT_WIDTH(ELEMENT_WIDTH)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.wr(wr),
		.wr_data(wr_data),
		.rd_addr(desc.idx[fi_q]),
		.rd_a(rd_a),
		.rd_b(rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= '0;
			e_q <= '0;
			t_q <= '0;
			fi_q <= '0;
			det_phase_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == S_EMIT && out_free) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q <= cmd.opcode;
						e_q <= '0;
						t_q <= '0;
						fi_q <= '0;
						det_phase_q <= (cmd.opcode == OP_INV2) || (cmd.opcode == OP_INV3);
						if (cmd.opcode inside {[OP_DET2:OP_ADD3]}) state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_MLO;
				S_MLO: begin
					if (fi_q != 2'd0) state_q <= S_MHI;
					else if (desc.fac_cnt == 2'd1) state_q <= S_ACC;
					else begin
						fi_q <= 2'd1;
						state_q <= S_RD;
					end
				end
				S_MHI: begin
					if (fi_q == desc.fac_cnt - 2'd1) state_q <= S_ACC;
					else begin
						fi_q <= fi_q + 2'd1;
						state_q <= S_RD;
					end
				end
				S_ACC: begin
					fi_q <= '0;
					if (t_q != nterm - 3'd1) begin
						t_q <= t_q + 3'd1;
						state_q <= S_RD;
					end else begin
						t_q <= '0;
						if (det_phase_q) begin
							det_phase_q <= 1'b0;
							state_q <= (acc_sum == 64'd0) ? S_EMIT : S_RD;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						if (res_q.last) state_q <= S_IDLE;
						else if (!inv_final) begin
							e_q <= e_q + 4'd1;
							state_q <= S_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: acc_q <= '0;
			S_RD: sel_b_q <= desc.from_b[fi_q];
			S_MLO: begin
				if (fi_q == 2'd0) prod_q <= desc.neg ? -64'(fac_rd) : 64'(fac_rd);
				else begin
					tmp_q <= 64'(mul_res);
					fac_q <= fac_rd;
				end
			end
			S_MHI: prod_q <= tmp_q + {mul_res[31:0], 32'h0};
			S_ACC: begin
				if (t_q != nterm - 3'd1) acc_q <= acc_sum;
				else begin
					acc_q <= '0;
					if (det_phase_q) begin
						det_q <= acc_sum;
						res_q <= '{result_value: '0, result_index: '0, is_determinant: 1'b1,
							status: 1'b1, last: 1'b1};
					end else begin
						res_q <= '{result_value: acc_sum[RESULT_WIDTH-1:0], result_index: e_q,
							is_determinant: is_det_op, status: 1'b0,
							last: is_det_op || (!is_inv && (e_q == nelem - 4'd1))};
					end
				end
			end
			S_EMIT: begin
				if (out_free) begin
					out_q <= res_q;
					if (inv_final) begin
						res_q <= '{result_value: det_q[RESULT_WIDTH-1:0], result_index: '0,
							is_determinant: 1'b1, status: 1'b0, last: 1'b1};
					end
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_singular_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status |-> res.is_determinant && res.last && res.result_value == '0)
		else $error("singular item malformed");
	a_mhi_factor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MHI |-> fi_q != 2'd0)
		else $error("multiply step on first factor");
	a_term_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ACC |-> t_q < nterm)
		else $error("term index out of range");
	a_singular_det: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT && res_q.status |-> det_q == 64'd0)
		else $error("singular status with nonzero determinant");
`endif

endmodule

[src/smu_store.sv]
// Element stores for matrices A and B with registered reads.
module smu_store
	import smu_pkg::*;
#(
	parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input smu_wr_t wr,
	input logic signed [ELEMENT_WIDTH-1:0] wr_data,
	input logic [3:0] rd_addr,
	output logic signed [ELEMENT_WIDTH-1:0] rd_a,
	output logic signed [ELEMENT_WIDTH-1:0] rd_b
);

	logic signed [ELEMENT_WIDTH-1:0] mem_a [DEPTH];
	logic signed [ELEMENT_WIDTH-1:0] mem_b [DEPTH];
	logic [DEPTH-1:0] va_q;
	logic [DEPTH-1:0] vb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_q <= '0;
			vb_q <= '0;
		end else begin
			if (wr.we_a) va_q[wr.addr] <= 1'b1;
			if (wr.we_b) vb_q[wr.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.we_a) mem_a[wr.addr] <= wr_data;
		if (wr.we_b) mem_b[wr.addr] <= wr_data;
		rd_a <= va_q[rd_addr] ? mem_a[rd_addr] : '0;
		rd_b <= vb_q[rd_addr] ? mem_b[rd_addr] : '0;
	end

endmodule
